@@ src/frame_diff_motion_bands_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the frame difference motion band unit
// ----------------------------------------------------------------------------
`ifndef FRAME_DIFF_MOTION_BANDS_UNIT_MACROS_SVH
`define FRAME_DIFF_MOTION_BANDS_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define FDMB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define FDMB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fdmb_pkg.sv @@
// ----------------------------------------------------------------------------
// fdmb_pkg
// Shared types, sizes and helpers of the frame difference motion band unit.
// ----------------------------------------------------------------------------
package fdmb_pkg;

  // Frame size and derived widths
  localparam int FRAME_PIXELS = 65536;
  localparam int POS_W        = $clog2(FRAME_PIXELS);
  localparam int CNT_W        = POS_W + 1;
  localparam int THRESH_W     = 10;
  localparam int SUM_W        = 10;
  localparam int PIX_W        = 24;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(70);
  localparam logic [7:0]          CHAN_MAX     = 8'hFF;

  // Band edges, compared against four times the position
  localparam logic [POS_W+1:0] EDGE_1 = (POS_W+2)'(FRAME_PIXELS);
  localparam logic [POS_W+1:0] EDGE_2 = (POS_W+2)'(2 * FRAME_PIXELS);
  localparam logic [POS_W+1:0] EDGE_3 = (POS_W+2)'(3 * FRAME_PIXELS);

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       moved;
    logic       band_valid;
    logic [1:0] busiest_band;
  } pix_out_t;

  // Counter update request toward the band tracker
  typedef struct packed {
    logic       fire;
    logic       moved;
    logic [1:0] band;
    logic       last;
  } band_upd_t;

  function automatic logic [7:0] abs_diff8(logic [7:0] a, logic [7:0] b);
    abs_diff8 = (a > b) ? (a - b) : (b - a);
  endfunction

  // Band index = floor(4 * pos / FRAME_PIXELS)
  function automatic logic [1:0] band_of(logic [POS_W-1:0] pos);
    logic [POS_W+1:0] pos4;
    pos4 = {pos, 2'b00};
    if (pos4 >= EDGE_3) begin
      band_of = 2'd3;
    end else if (pos4 >= EDGE_2) begin
      band_of = 2'd2;
    end else if (pos4 >= EDGE_1) begin
      band_of = 2'd1;
    end else begin
      band_of = 2'd0;
    end
  endfunction

endpackage

@@ src/fdmb_frame_store.sv @@
// ----------------------------------------------------------------------------
// fdmb_frame_store
// Previous-frame pixel memory with a registered read port. A fill count marks
// the written prefix so unwritten entries read as zero, and a same-cycle
// write to the read address is forwarded.
// ----------------------------------------------------------------------------
module fdmb_frame_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic [fdmb_pkg::POS_W-1:0]      rd_addr,
  output logic [fdmb_pkg::PIX_W-1:0]      rd_data,
  input  logic                            wr_en,
  input  logic [fdmb_pkg::POS_W-1:0]      wr_addr,
  input  logic [fdmb_pkg::PIX_W-1:0]      wr_data
);

  logic [fdmb_pkg::PIX_W-1:0] mem_r [fdmb_pkg::FRAME_PIXELS];
  logic [fdmb_pkg::PIX_W-1:0] ram_q_r;
  logic [fdmb_pkg::PIX_W-1:0] fwd_data_r;
  logic                       fwd_r;
  logic                       blank_r;
  logic [fdmb_pkg::CNT_W-1:0] fill_r;
  logic [fdmb_pkg::CNT_W-1:0] fill_nxt;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      ram_q_r <= mem_r[rd_addr];
    end
  end

  // Capture forwarding and never-written flags with the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
      blank_r    <= ({1'b0, rd_addr} >= fill_r);
    end
  end

  // Advance the fill count when the write extends the written prefix
  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && ({1'b0, wr_addr} == fill_r) &&
        (fill_r != fdmb_pkg::CNT_W'(fdmb_pkg::FRAME_PIXELS))) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign rd_data = fwd_r   ? fwd_data_r :
                   blank_r ? '0         : ram_q_r;

endmodule

@@ src/fdmb_band_tracker.sv @@
// ----------------------------------------------------------------------------
// fdmb_band_tracker
// Four moved-pixel counters and the first-maximum search over them, with the
// current pixel's count folded in.
// ----------------------------------------------------------------------------
module fdmb_band_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fdmb_pkg::band_upd_t  upd,
  output logic [1:0]           busiest
);

  logic [fdmb_pkg::CNT_W-1:0] cnt_r   [4];
  logic [fdmb_pkg::CNT_W-1:0] cnt_eff [4];
  logic [1:0]                 best01;
  logic [1:0]                 best23;
  logic [fdmb_pkg::CNT_W-1:0] max01;
  logic [fdmb_pkg::CNT_W-1:0] max23;

  // Fold in the current word's moved flag
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cnt_eff[i] = cnt_r[i] +
                   fdmb_pkg::CNT_W'(upd.moved && (upd.band == 2'(i)));
    end
  end

  // Pick the first maximum through a two-level tree
  always_comb begin
    best01  = (cnt_eff[1] > cnt_eff[0]) ? 2'd1 : 2'd0;
    max01   = (cnt_eff[1] > cnt_eff[0]) ? cnt_eff[1] : cnt_eff[0];
    best23  = (cnt_eff[3] > cnt_eff[2]) ? 2'd3 : 2'd2;
    max23   = (cnt_eff[3] > cnt_eff[2]) ? cnt_eff[3] : cnt_eff[2];
    busiest = (max23 > max01) ? best23 : best01;
  end

  // Count, or clear after the last pixel of a frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (upd.fire) begin
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= upd.last ? '0 : cnt_eff[i];
      end
    end
  end

endmodule

@@ src/frame_diff_motion_bands_unit.sv @@
// ----------------------------------------------------------------------------
// frame_diff_motion_bands_unit
// Frame difference motion detector: compares each pixel with the stored
// previous frame, highlights moved pixels and reports the busiest of four
// bands at the end of each frame.
//
//   channel  ports                              word
//   in       in_valid / in_ready / in_data      pix_in_t, one pixel
//   out      out_valid / out_ready / out_data   pix_out_t, one result
//   cfg      cfg_wr_en / cfg_wr_data            motion threshold, 10 bits
//
// One pixel per clock while out is not stalled. The stages are the frame store's
// registered read, the compare register and the output register.
// After reset the frame store needs no clearing pass: a fill count makes
// never-written entries read as zero, so pixels are taken at once.
// A stall on out holds only the stages that are full; bubbles are squeezed.
// ----------------------------------------------------------------------------
module frame_diff_motion_bands_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fdmb_pkg::pix_in_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fdmb_pkg::pix_out_t              out_data,
  input  logic                            cfg_wr_en,
  input  logic [fdmb_pkg::THRESH_W-1:0]   cfg_wr_data
);

  logic [fdmb_pkg::THRESH_W-1:0] thresh_r;
  logic [fdmb_pkg::POS_W-1:0]    pos_r;
  logic [fdmb_pkg::POS_W-1:0]    pos_nxt;

  // Stage 1: pixel waiting for stored data
  logic                          v1_r;
  fdmb_pkg::pix_in_t             s1_pix_r;
  logic [fdmb_pkg::POS_W-1:0]    s1_pos_r;

  // Stage 2: compared pixel
  logic                          v2_r;
  logic [7:0]                    s2_red_r;
  logic [7:0]                    s2_green_r;
  logic [7:0]                    s2_blue_r;
  logic                          s2_moved_r;
  logic [1:0]                    s2_band_r;
  logic                          s2_last_r;

  // Stage 3: output register
  logic                          v3_r;
  fdmb_pkg::pix_out_t            out_r;

  logic                          en1;
  logic                          en2;
  logic                          en3;
  logic                          in_fire;
  logic [fdmb_pkg::PIX_W-1:0]    old_pix;
  logic [fdmb_pkg::SUM_W-1:0]    diff_sum;
  logic                          moved;
  logic [1:0]                    busiest;
  fdmb_pkg::band_upd_t           upd;

  // Advance each stage when the next one is empty or advancing
  assign en3     = !v3_r || out_ready;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign in_ready = en1;
  assign in_fire = in_valid && en1;

  fdmb_frame_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (pos_r),
    .rd_data (old_pix),
    .wr_en   (v1_r && en2),
    .wr_addr (s1_pos_r),
    .wr_data ({s1_pix_r.red_in, s1_pix_r.green_in, s1_pix_r.blue_in})
  );

  // Sum channel differences and compare against the threshold
  always_comb begin
    diff_sum = fdmb_pkg::SUM_W'(fdmb_pkg::abs_diff8(s1_pix_r.red_in,   old_pix[23:16]))
             + fdmb_pkg::SUM_W'(fdmb_pkg::abs_diff8(s1_pix_r.green_in, old_pix[15:8]))
             + fdmb_pkg::SUM_W'(fdmb_pkg::abs_diff8(s1_pix_r.blue_in,  old_pix[7:0]));
    moved = diff_sum > thresh_r;
  end

  // Advance the pixel position, restart on frame end or at the frame size
  always_comb begin
    if (in_data.frame_end ||
        (pos_r == fdmb_pkg::POS_W'(fdmb_pkg::FRAME_PIXELS - 1))) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  assign upd = '{fire: v2_r && en3, moved: s2_moved_r, band: s2_band_r,
                 last: s2_last_r};

  fdmb_band_tracker u_bands (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd     (upd),
    .busiest (busiest)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= fdmb_pkg::THRESH_RESET;
      pos_r    <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      if (in_fire) begin
        pos_r <= pos_nxt;
      end
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r <= in_data;
      s1_pos_r <= pos_r;
    end
    if (v1_r && en2) begin
      s2_red_r   <= moved ? fdmb_pkg::CHAN_MAX : s1_pix_r.red_in;
      s2_green_r <= moved ? fdmb_pkg::CHAN_MAX : s1_pix_r.green_in;
      s2_blue_r  <= moved ? fdmb_pkg::CHAN_MAX : s1_pix_r.blue_in;
      s2_moved_r <= moved;
      s2_band_r  <= fdmb_pkg::band_of(s1_pos_r);
      s2_last_r  <= s1_pix_r.frame_end;
    end
    if (v2_r && en3) begin
      out_r.red_out      <= s2_red_r;
      out_r.green_out    <= s2_green_r;
      out_r.blue_out     <= s2_blue_r;
      out_r.moved        <= s2_moved_r;
      out_r.band_valid   <= s2_last_r;
      out_r.busiest_band <= s2_last_r ? busiest : 2'd0;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

endmodule

@@ src/fdmb_checker.sv @@
// ----------------------------------------------------------------------------
// fdmb_checker
// Port-level checks of the frame difference motion band unit, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "frame_diff_motion_bands_unit_macros.svh"

module fdmb_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                out_valid,
  input  logic                out_ready,
  input  fdmb_pkg::pix_out_t  out_data
);

  // Hold a stalled result word
  `FDMB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out word changed while stalled")

  // Report a band only on the last pixel
  `FDMB_ASSERT_ALWAYS(a_no_band, !out_valid || out_data.band_valid || (out_data.busiest_band == 2'd0), "busiest_band set without report")

  // Drive moved pixels white
  `FDMB_ASSERT_ALWAYS(a_moved_white, !out_valid || !out_data.moved || ((out_data.red_out == 8'hFF) && (out_data.green_out == 8'hFF) && (out_data.blue_out == 8'hFF)), "moved pixel not white")

endmodule

bind frame_diff_motion_bands_unit fdmb_checker u_fdmb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
